### design/exponential_random_variate_top_macros.svh
// assertion macros for the exponential random variate block
`ifndef EXPONENTIAL_RANDOM_VARIATE_TOP_MACROS_SVH
`define EXPONENTIAL_RANDOM_VARIATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// consequent holds in the same cycle as the antecedent
`define ERV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erv assertion failed");
// consequent holds in the cycle after the antecedent
`define ERV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erv assertion failed");
`else
`define ERV_ASSERT_SAME(label, clk, rst, ante, cons)
`define ERV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/erv_pkg.sv
// shared constants, types and the log2 table of the exponential variate block
package erv_pkg;

   localparam int LOG_TABLE_BITS = 8;
   localparam int FRAC_BITS      = 30;
   localparam int REM_BITS       = FRAC_BITS - LOG_TABLE_BITS;
   localparam int TABLE_SIZE     = (1 << LOG_TABLE_BITS) + 1;
   localparam int TAB_AW         = $clog2(TABLE_SIZE);
   localparam int LOG_FRAC       = 24;
   localparam int LOG_ENTRY_W    = LOG_FRAC + 1;
   localparam int X_W            = 31;
   localparam int MEAN_W         = 24;
   localparam int VARIATE_W      = 32;
   localparam int LZ_W           = 5;
   localparam int NEG_W          = 29;
   localparam int NEGLN_W        = 29;
   localparam int MUL_W          = 32;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int NORM_STEPS     = 5;
   localparam int NORM_IDX_W     = 3;

   localparam logic [X_W-1:0]   LCG_M   = 31'h7FFF_FFFF;
   localparam logic [MUL_W-1:0] LCG_A   = 32'd16807;
   localparam logic [MUL_W-1:0] LN2_Q30 = 32'd744261118;

   typedef logic [TABLE_SIZE-1:0][LOG_ENTRY_W-1:0] log_table_type;

   // log2(1 + i/2^LOG_TABLE_BITS) in Q1.24 by repeated squaring
   function automatic log_table_type build_log_table();
      log_table_type t;
      logic [63:0]   y;
      logic [23:0]   r;
      int            i;
      int            n;
      t = '0;
      for (i = 0; i < TABLE_SIZE - 1; i++) begin
         y = (64'd1 << FRAC_BITS) + (64'(i) << REM_BITS);
         r = '0;
         for (n = 0; n < LOG_FRAC; n++) begin
            y = (y * y) >> FRAC_BITS;
            r = {r[22:0], 1'b0};
            if (y >= (64'd2 << FRAC_BITS)) begin
               y = y >> 1;
               r[0] = 1'b1;
            end
         end
         t[i] = {1'b0, r};
      end
      t[TABLE_SIZE-1] = LOG_ENTRY_W'(1) << LOG_FRAC;
      return t;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

   typedef enum logic [1:0] {
      MUL_LCG    = 2'd0,
      MUL_INTERP = 2'd1,
      MUL_LN     = 2'd2,
      MUL_MEAN   = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic                  load_mean;
      logic                  seed_load;
      logic                  mul_en;
      mul_sel_type           mul_sel;
      logic                  lcg_fold;
      logic                  norm_en;
      logic [NORM_IDX_W-1:0] norm_idx;
      logic                  rom_rd;
      logic                  rom_hi;
      logic                  log_sub;
      logic                  out_load;
   } cmd_type;

endpackage

### design/erv_ctrl.sv
// sequencer of the exponential variate block: handshakes and datapath commands
`include "exponential_random_variate_top_macros.svh"
module erv_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  logic            csr_valid,
   output logic            csr_ready,
   output erv_pkg::cmd_type cmd
);
   import erv_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_LCG      = 11'b00000000010,
      S_FOLD     = 11'b00000000100,
      S_NORM     = 11'b00000001000,
      S_TAB_LO   = 11'b00000010000,
      S_TAB_HI   = 11'b00000100000,
      S_MUL_INT  = 11'b00001000000,
      S_LOG_SUB  = 11'b00010000000,
      S_MUL_LN   = 11'b00100000000,
      S_MUL_MEAN = 11'b01000000000,
      S_DONE     = 11'b10000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [NORM_IDX_W-1:0] norm_cnt_ff, norm_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  idle;
   logic                  req_take;
   logic                  out_free;
   logic                  norm_last;

   assign idle      = (state_ff == S_IDLE);
   assign req_stall = !idle;
   assign csr_ready = idle;
   assign req_take  = req_valid && idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign norm_last = (norm_cnt_ff == NORM_IDX_W'(NORM_STEPS - 1));

   always_comb begin
      state_in    = state_ff;
      norm_cnt_in = norm_cnt_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_LCG;
      cmd.norm_idx = norm_cnt_ff;
      cmd.seed_load = csr_valid && csr_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd.load_mean = 1'b1;
               state_in      = S_LCG;
            end
         end
         S_LCG: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LCG;
            state_in    = S_FOLD;
         end
         S_FOLD: begin
            cmd.lcg_fold = 1'b1;
            norm_cnt_in  = '0;
            state_in     = S_NORM;
         end
         S_NORM: begin
            cmd.norm_en = 1'b1;
            norm_cnt_in = norm_cnt_ff + NORM_IDX_W'(1);
            if (norm_last) begin
               state_in = S_TAB_LO;
            end
         end
         S_TAB_LO: begin
            cmd.rom_rd = 1'b1;
            state_in   = S_TAB_HI;
         end
         S_TAB_HI: begin
            cmd.rom_rd = 1'b1;
            cmd.rom_hi = 1'b1;
            state_in   = S_MUL_INT;
         end
         S_MUL_INT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INTERP;
            state_in    = S_LOG_SUB;
         end
         S_LOG_SUB: begin
            cmd.log_sub = 1'b1;
            state_in    = S_MUL_LN;
         end
         S_MUL_LN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LN;
            state_in    = S_MUL_MEAN;
         end
         S_MUL_MEAN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MEAN;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // wait here until the output register can take the transaction
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         norm_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         norm_cnt_ff  <= norm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ERV_ASSERT_NEXT(a_take_starts_lcg, clock, reset, req_valid && !req_stall, state_ff == S_LCG)
   `ERV_ASSERT_SAME(a_out_load_free, clock, reset, cmd.out_load, !rsp_valid_ff || !rsp_stall)
   `ERV_ASSERT_NEXT(a_norm_exit, clock, reset, state_ff == S_NORM && norm_last, state_ff == S_TAB_LO)
   `ERV_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.out_load, rsp_valid_ff)

endmodule

### design/erv_datapath.sv
// datapath: lcg state, shared multiplier, normalizer, log2 table and output registers
`include "exponential_random_variate_top_macros.svh"
module erv_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  erv_pkg::cmd_type               cmd,
   input  logic [erv_pkg::MEAN_W-1:0]     req_mean_value,
   input  logic [erv_pkg::X_W-1:0]        csr_seed,
   output logic [erv_pkg::VARIATE_W-1:0]  rsp_variate,
   output logic [erv_pkg::X_W-1:0]        rsp_uniform_word
);
   import erv_pkg::*;

   logic [X_W-1:0]         x_ff, x_in;
   logic [MEAN_W-1:0]      mean_ff;
   logic [PROD_W-1:0]      mul_ff;
   logic [X_W-1:0]         norm_ff, norm_in;
   logic [LZ_W-1:0]        lz_ff, lz_in;
   logic [LOG_ENTRY_W-1:0] rom_ff;
   logic [LOG_ENTRY_W-1:0] lo_ff;
   logic [NEG_W-1:0]       neglog_ff, neglog_in;
   logic [VARIATE_W-1:0]   variate_ff;
   logic [X_W-1:0]         uniform_ff;

   logic [MUL_W-1:0]       op_a, op_b;
   logic [X_W:0]           fold_sum;
   logic [X_W-1:0]         fold_x;
   logic [LZ_W-1:0]        shift_amt;
   logic                   top_zero;
   logic [TAB_AW-1:0]      rom_addr;
   logic [LOG_ENTRY_W-1:0] interp_inc;
   logic [LOG_ENTRY_W-1:0] diff;

   // seed load: zero and the modulus both map to 1
   always_comb begin
      x_in = x_ff;
      if (cmd.seed_load) begin
         if (csr_seed == '0 || csr_seed == LCG_M) begin
            x_in = X_W'(1);
         end else begin
            x_in = csr_seed;
         end
      end else if (cmd.lcg_fold) begin
         x_in = fold_x;
      end
   end

   // x * 16807 mod (2^31 - 1) by folding the high part onto the low part
   always_comb begin
      fold_sum = {1'b0, mul_ff[X_W-1:0]} + (X_W + 1)'(mul_ff[PROD_W-1:X_W]);
      if (fold_sum >= {1'b0, LCG_M}) begin
         fold_x = X_W'(fold_sum - {1'b0, LCG_M});
      end else begin
         fold_x = fold_sum[X_W-1:0];
      end
   end

   // shared multiplier operand select
   assign diff = rom_ff - lo_ff;
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_LCG: begin
            op_a = MUL_W'(x_ff);
            op_b = LCG_A;
         end
         MUL_INTERP: begin
            op_a = MUL_W'(diff);
            op_b = MUL_W'(norm_ff[REM_BITS-1:0]);
         end
         MUL_LN: begin
            op_a = MUL_W'(neglog_ff);
            op_b = LN2_Q30;
         end
         MUL_MEAN: begin
            op_a = MUL_W'(mean_ff);
            op_b = MUL_W'(mul_ff[FRAC_BITS +: NEGLN_W]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // one binary-search step of the leading-one normalizer: 16, 8, 4, 2, 1
   always_comb begin
      shift_amt = LZ_W'(5'd16 >> cmd.norm_idx);
      top_zero  = (norm_ff >> (6'(X_W) - 6'(shift_amt))) == '0;
      norm_in   = norm_ff;
      lz_in     = lz_ff;
      if (cmd.lcg_fold) begin
         norm_in = fold_x;
         lz_in   = '0;
      end else if (cmd.norm_en && top_zero) begin
         norm_in = norm_ff << shift_amt;
         lz_in   = lz_ff + shift_amt;
      end
   end

   assign rom_addr = {1'b0, norm_ff[FRAC_BITS-1:REM_BITS]} + TAB_AW'(cmd.rom_hi);

   // -log2 z = (31 - p) - log2 mantissa, with 31 - p = lz + 1
   assign interp_inc = mul_ff[REM_BITS +: LOG_ENTRY_W];
   assign neglog_in  = NEG_W'({lz_ff + LZ_W'(1), {LOG_FRAC{1'b0}}})
                       - NEG_W'(lo_ff) - NEG_W'(interp_inc);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= X_W'(1);
      end else begin
         x_ff <= x_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff <= norm_in;
      lz_ff   <= lz_in;
      if (cmd.load_mean) begin
         mean_ff <= req_mean_value;
      end
      if (cmd.mul_en) begin
         mul_ff <= op_a * op_b;
      end
      if (cmd.rom_rd) begin
         rom_ff <= LOG_TABLE[rom_addr];
      end
      if (cmd.rom_hi) begin
         lo_ff <= rom_ff;
      end
      if (cmd.log_sub) begin
         neglog_ff <= neglog_in;
      end
      // the product stays below 2^53, so the Q16.16 result never reaches saturation
      if (cmd.out_load) begin
         variate_ff <= VARIATE_W'(mul_ff[LOG_FRAC +: NEGLN_W]);
         uniform_ff <= x_ff;
      end
   end

   assign rsp_variate      = variate_ff;
   assign rsp_uniform_word = uniform_ff;

   `ERV_ASSERT_NEXT(a_lcg_in_range, clock, reset, cmd.lcg_fold, x_ff != '0 && x_ff != LCG_M)
   `ERV_ASSERT_SAME(a_norm_done, clock, reset, cmd.rom_rd && !cmd.rom_hi, norm_ff[X_W-1])
   `ERV_ASSERT_NEXT(a_seed_nonzero, clock, reset, cmd.seed_load, x_ff != '0)

endmodule

### design/exponential_random_variate_top.sv
// Exponential random variate generator, top level.
// Each accepted request carries a Q8.16 mean; the block advances the
// 31-bit minimal standard generator (x = 16807 * x mod 2^31-1) and returns
// mean * -ln(x / 2^31) in Q16.16 together with the new generator word.
// New requests are accepted only while the sequencer is idle. It runs
// every step through one shared 32x32 multiplier (generator update, log
// interpolation, ln 2 scaling, mean scaling), a five-step leading-one
// normalizer and two registered reads of the 257-entry log2 table. A
// finished result waits in an output register, so the next request is
// accepted while it is stalled. A seed write is taken only while no
// request is in progress; a seed of 0 or 2^31-1 loads 1.
module exponential_random_variate_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [erv_pkg::MEAN_W-1:0]     req_mean_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [erv_pkg::VARIATE_W-1:0]  rsp_variate,
   output logic [erv_pkg::X_W-1:0]        rsp_uniform_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [erv_pkg::X_W-1:0]        csr_seed
);
   import erv_pkg::*;

   cmd_type cmd;

   erv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   erv_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mean_value   (req_mean_value),
      .csr_seed         (csr_seed),
      .rsp_variate      (rsp_variate),
      .rsp_uniform_word (rsp_uniform_word)
   );

endmodule

### verif/erv_variate_checker.sv
// transaction monitor, exponential variate predictor and result checker
module erv_variate_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [erv_pkg::MEAN_W-1:0]     req_mean_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [erv_pkg::VARIATE_W-1:0]  rsp_variate,
   input  logic [erv_pkg::X_W-1:0]        rsp_uniform_word,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [erv_pkg::X_W-1:0]        csr_seed,
   output int                             mismatch_count,
   output int                             draws_pending
);
   import erv_pkg::*;

   localparam longint SCHRAGE_Q = 127773;
   localparam longint SCHRAGE_R = 2836;
   localparam longint MODULUS   = 64'(LCG_M);

   typedef struct packed {
      logic [VARIATE_W-1:0] variate;
      logic [X_W-1:0]       uniform_word;
   } draw_result_type;

   bit [31:0]        log2_frac_q24 [TABLE_SIZE];
   bit [X_W-1:0]     gen_state;
   draw_result_type  expected_draws [$];

   // fractional log2 of 1 + i/2^LOG_TABLE_BITS by repeated squaring
   initial begin
      bit [63:0] y;
      bit [31:0] r;
      for (int i = 0; i < TABLE_SIZE - 1; i++) begin
         y = (64'd1 << FRAC_BITS) + (64'(i) << REM_BITS);
         r = 0;
         for (int n = 0; n < 24; n++) begin
            y = (y * y) >> FRAC_BITS;
            r = r << 1;
            if (y >= (64'd2 << FRAC_BITS)) begin
               y = y >> 1;
               r = r | 1;
            end
         end
         log2_frac_q24[i] = r;
      end
      log2_frac_q24[TABLE_SIZE-1] = 32'd1 << 24;
   end

   function automatic bit [X_W-1:0] seed_to_state(input bit [X_W-1:0] v);
      bit [X_W-1:0] s;
      s = v;
      if (s >= LCG_M) s = s - LCG_M;
      if (s == 0) s = 1;
      return s;
   endfunction

   // schrage split keeps every product inside 64 bits
   function automatic bit [X_W-1:0] next_minstd(input bit [X_W-1:0] x);
      longint hi;
      longint lo;
      longint t;
      hi = longint'(x) / SCHRAGE_Q;
      lo = longint'(x) % SCHRAGE_Q;
      t = 64'(LCG_A) * lo - SCHRAGE_R * hi;
      if (t <= 0) t = t + MODULUS;
      return t[X_W-1:0];
   endfunction

   function automatic bit [VARIATE_W-1:0] exp_variate(input bit [MEAN_W-1:0] mean,
                                                      input bit [X_W-1:0] x);
      int unsigned p;
      bit [31:0]   mant;
      bit [31:0]   frac;
      bit [31:0]   k;
      bit [31:0]   rem;
      bit [31:0]   interp;
      bit [31:0]   log2x;
      bit [31:0]   neglog2;
      bit [63:0]   wide;
      bit [63:0]   negln;
      bit [63:0]   prod;
      p = 0;
      while (p < 30 && (x >> (p + 1)) != 0) p++;
      mant = 32'(x) << (FRAC_BITS - p);
      frac = mant - (32'd1 << FRAC_BITS);
      k = frac >> REM_BITS;
      rem = frac & ((32'd1 << REM_BITS) - 1);
      wide = 64'(log2_frac_q24[k+1] - log2_frac_q24[k]);
      wide = wide * 64'(rem);
      interp = log2_frac_q24[k] + 32'(wide >> REM_BITS);
      log2x = (p << 24) + interp;
      neglog2 = (32'd31 << 24) - log2x;
      negln = (64'(neglog2) * 64'(LN2_Q30)) >> FRAC_BITS;
      prod = (64'(mean) * negln) >> 24;
      if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
      return prod[31:0];
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      draw_result_type want;
      if (reset) begin
         gen_state = 1;
         expected_draws.delete();
         mismatch_count = 0;
         draws_pending <= 0;
      end else begin
         if (csr_valid && csr_ready) gen_state = seed_to_state(csr_seed);
         if (req_valid && !req_stall) begin
            if (gen_state == 0 || gen_state >= LCG_M) gen_state = 1;
            gen_state = next_minstd(gen_state);
            want.uniform_word = gen_state;
            want.variate = exp_variate(req_mean_value, gen_state);
            expected_draws.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_draws.size() == 0) begin
               report_mismatch("unrequested result, variate", 0, rsp_variate);
            end else begin
               want = expected_draws.pop_front();
               if (rsp_variate !== want.variate)
                  report_mismatch("variate", want.variate, rsp_variate);
               if (rsp_uniform_word !== want.uniform_word)
                  report_mismatch("uniform_word", want.uniform_word, rsp_uniform_word);
            end
         end
         draws_pending <= expected_draws.size();
      end
   end

endmodule

### verif/exponential_random_variate_top_tb.sv
// stimulus and verdict for the exponential random variate block
module exponential_random_variate_top_tb;
   import erv_pkg::*;

   localparam int PHASE_DRAWS = 325;
   localparam int LONG_HOLD   = 400;
   // seeds whose next word is 1 and 2^31-2, the ends of the uniform range
   localparam logic [X_W-1:0] SEED_TO_ONE = 31'd1407677000;
   localparam logic [X_W-1:0] SEED_TO_TOP = 31'd739806647;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [MEAN_W-1:0]     req_mean_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [VARIATE_W-1:0]  rsp_variate;
   logic [X_W-1:0]        rsp_uniform_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [X_W-1:0]        csr_seed;
   int                    mismatch_count;
   int                    draws_pending;

   bit sender_quiet;
   bit receiver_quiet;
   bit hold_off_req;

   exponential_random_variate_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mean_value   (req_mean_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_variate      (rsp_variate),
      .rsp_uniform_word (rsp_uniform_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed         (csr_seed)
   );

   erv_variate_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mean_value   (req_mean_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_variate      (rsp_variate),
      .rsp_uniform_word (rsp_uniform_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed         (csr_seed),
      .mismatch_count   (mismatch_count),
      .draws_pending    (draws_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!receiver_quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   function automatic logic [MEAN_W-1:0] choose_mean();
      case ($urandom_range(0, 3))
         0: return MEAN_W'($urandom);
         1: return MEAN_W'($urandom_range(0, 32'hFFFF));
         2: return 24'hF00000 | MEAN_W'($urandom_range(0, 32'hFFFFF));
         default: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      endcase
   endfunction

   task automatic send_draw(input logic [MEAN_W-1:0] mean);
      if (!sender_quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mean_value <= mean;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait for every outstanding transaction to return
   task automatic drain_draws();
      req_valid <= 1'b0;
      do @(posedge clock); while (draws_pending != 0);
   endtask

   task automatic write_seed(input logic [X_W-1:0] value);
      drain_draws();
      csr_valid <= 1'b1;
      csr_seed <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mean_value = '0;
      csr_valid = 1'b0;
      csr_seed = '0;
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
      hold_off_req = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: mean extremes from the reset seed, then seed corner cases
      send_draw(24'h000000);
      send_draw(24'hFFFFFF);
      send_draw(24'h000001);
      send_draw(24'h010000);
      send_draw(24'hAAAAAA);
      send_draw(24'h555555);
      write_seed(31'd0);
      send_draw(24'hFFFFFF);
      send_draw(24'h800000);
      write_seed(LCG_M);
      send_draw(24'hFFFFFF);
      write_seed(31'h7FFF_FFFE);
      send_draw(24'hFFFFFF);
      send_draw(24'h000001);
      write_seed(SEED_TO_ONE);
      send_draw(24'hFFFFFF);
      write_seed(SEED_TO_TOP);
      send_draw(24'hFFFFFF);
      write_seed(31'd1);
      send_draw(24'h7FFFFF);

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0)
            write_seed(X_W'($urandom));
         else
            write_seed(X_W'($urandom_range(1, 32'h7FFF_FFFE)));
         if (phase == 1) hold_off_req = 1'b1;
         if (phase == 3) begin
            sender_quiet = 1'b1;
            receiver_quiet = 1'b1;
         end
         for (int n = 0; n < PHASE_DRAWS; n++) begin
            if (phase == 2 && n == PHASE_DRAWS / 2) drain_draws();
            send_draw(choose_mean());
         end
      end

      drain_draws();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && draws_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
